@@ rtl/lzss_window_decoder_core_assert.svh @@
// Assertion macros for the LZSS window decoder checker.
// Pure text macros; no dependencies.
`ifndef LZSS_WINDOW_DECODER_CORE_ASSERT_SVH
`define LZSS_WINDOW_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZWD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LZWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lzwd_pkg.sv @@
// Shared types and constants for the LZSS window decoder.
// No dependencies; imported by every module of the block.
package lzwd_pkg;

    // Configuration register file.
    localparam int CFG_W = 24;
    localparam logic [CFG_W-1:0] OUT_LENGTH_RST  = 24'd4096;
    localparam logic [CFG_W-1:0] TOKEN_LIMIT_DFLT = 24'd200000;

    localparam logic REG_OUT_LENGTH  = 1'b0;
    localparam logic REG_TOKEN_LIMIT = 1'b1;

    // History window geometry.
    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW    = 12;

    // Command queue between the front and the back.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = 2;

    // Run status codes.
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_LEN   = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_TOK   = 2'd3;

    // Command kinds produced by the front.
    localparam logic [1:0] K_CTRL = 2'd0;
    localparam logic [1:0] K_LIT  = 2'd1;
    localparam logic [1:0] K_REF0 = 2'd2;
    localparam logic [1:0] K_COPY = 2'd3;

    // One classified input byte. For a literal, data[7:0] is the byte; for a copy,
    // data is the window position and len the length minus three.
    typedef struct packed {
        logic [1:0]        kind;
        logic [WIN_AW-1:0] data;
        logic [3:0]        len;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] out_length;
        logic [CFG_W-1:0] token_limit;
    } cfg_t;

endpackage

@@ rtl/lzwd_cmd_fifo.sv @@
// Small command queue that decouples the token front from the copy back.
// Depends on lzwd_pkg for the command type and depth.
module lzwd_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lzwd_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output lzwd_pkg::cmd_t head,
    output logic          empty
);
    import lzwd_pkg::*;

    cmd_t              entry_reg [CMD_DEPTH];
    logic [CMD_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_AW:0]   count_reg, count_next;

    assign full  = (count_reg == (CMD_AW+1)'(CMD_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/lzwd_front.sv @@
// Token front: tracks the control flags and turns each input byte into a command.
// Depends on lzwd_pkg for the command type and kind codes.
module lzwd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_in_byte,
    input  logic           s_in_last,
    input  logic           q_full,
    output logic           q_push,
    output lzwd_pkg::cmd_t q_data
);
    import lzwd_pkg::*;

    localparam logic [1:0] PH_CTRL = 2'd0;
    localparam logic [1:0] PH_LIT  = 2'd1;
    localparam logic [1:0] PH_REF0 = 2'd2;
    localparam logic [1:0] PH_REF1 = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] flag_reg, flag_next;
    logic [7:0]  held_reg;
    logic [15:0] flag_shifted;
    logic [1:0]  phase_after_token;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Phase that follows a finished token, taken from the next flag.
    assign flag_shifted = {1'b0, flag_reg[15:1]};
    always_comb begin
        if (!flag_shifted[8]) begin
            phase_after_token = PH_CTRL;
        end else if (flag_shifted[0]) begin
            phase_after_token = PH_LIT;
        end else begin
            phase_after_token = PH_REF0;
        end
    end

    // Classify the byte and advance the flag state on each transfer.
    always_comb begin
        phase_next  = phase_reg;
        flag_next   = flag_reg;
        q_data.kind = K_CTRL;
        q_data.data = {4'h0, s_in_byte};
        q_data.len  = s_in_byte[3:0];
        q_data.last = s_in_last;
        case (phase_reg)
            PH_CTRL: begin
                q_data.kind = K_CTRL;
                flag_next   = {8'hff, s_in_byte};
                phase_next  = s_in_byte[0] ? PH_LIT : PH_REF0;
            end
            PH_LIT: begin
                q_data.kind = K_LIT;
                flag_next   = flag_shifted;
                phase_next  = phase_after_token;
            end
            PH_REF0: begin
                q_data.kind = K_REF0;
                phase_next  = PH_REF1;
            end
            PH_REF1: begin
                q_data.kind = K_COPY;
                q_data.data = {s_in_byte[7:4], held_reg};
                flag_next   = flag_shifted;
                phase_next  = phase_after_token;
            end
            default: begin
                phase_next = PH_CTRL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CTRL;
            flag_reg  <= '0;
        end else if (q_push) begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
        end
    end

    // The first reference byte is held until its partner arrives.
    always_ff @(posedge aclk) begin
        if (q_push && (phase_reg == PH_REF0)) begin
            held_reg <= s_in_byte;
        end
    end

endmodule

@@ rtl/lzwd_back.sv @@
// Copy back: executes commands, owns the history window, counters and output register.
// Depends on lzwd_pkg for command, configuration and status definitions.
module lzwd_back #(
    parameter int COUNT_BITS = 24
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  lzwd_pkg::cfg_t cfg,
    input  lzwd_pkg::cmd_t head,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_out_valid,
    output logic           m_run_last,
    output logic [1:0]     m_status
);
    import lzwd_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    localparam logic B_IDLE = 1'b0;
    localparam logic B_COPY = 1'b1;

    logic                  state_reg, state_next;
    logic [1:0]            fin_reg, fin_next;
    logic [COUNT_BITS-1:0] prod_reg, prod_next, prod_inc;
    logic [COUNT_BITS-1:0] tok_reg, tok_next, tok_inc;
    logic [WIN_AW-1:0]     wp_reg, wp_next;
    logic                  wrapped_reg, wrapped_next;
    logic [WIN_AW-1:0]     cur_pos_reg, cur_pos_next;
    logic [4:0]            remain_reg, remain_next;
    logic                  last_reg, last_next;

    logic [7:0]            win_mem [WIN_DEPTH];
    logic [7:0]            rd_data_reg;
    logic                  fwd_reg;
    logic [7:0]            fwd_data_reg;
    logic                  zero_reg;

    logic                  m_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_valid_reg;
    logic                  run_last_reg;
    logic [1:0]            status_reg;

    logic                  slot_free;
    logic [CFG_W-1:0]      lim;
    logic [7:0]            copy_byte;
    logic                  we;
    logic [7:0]            wd;
    logic                  rd_en;
    logic [WIN_AW-1:0]     rd_addr;
    logic                  out_load;
    logic [7:0]            ob;
    logic                  ov;
    logic                  ol;
    logic [1:0]            os;
    logic                  len_done;

    // Stop check after a token: length first, then the token limit, then truncation.
    function automatic logic [1:0] stop_eval(
        input logic [COUNT_BITS-1:0] prod,
        input logic [COUNT_BITS-1:0] tok,
        input logic [CFG_W-1:0]      out_len,
        input logic [CFG_W-1:0]      tok_lim,
        input logic                  last
    );
        logic [1:0] res;
        if (CMP_W'(prod) >= CMP_W'(out_len)) begin
            res = ST_LEN;
        end else if (CMP_W'(tok) >= CMP_W'(tok_lim)) begin
            res = ST_TOK;
        end else if (last) begin
            res = ST_TRUNC;
        end else begin
            res = ST_RUN;
        end
        return res;
    endfunction

    assign slot_free = !m_valid_reg || m_ready;
    assign lim       = (cfg.token_limit == '0) ? TOKEN_LIMIT_DFLT : cfg.token_limit;
    assign prod_inc  = (prod_reg == '1) ? prod_reg : prod_reg + COUNT_BITS'(1);
    assign tok_inc   = (tok_reg == '1) ? tok_reg : tok_reg + COUNT_BITS'(1);
    assign len_done  = (CMP_W'(prod_inc) >= CMP_W'(cfg.out_length));

    // Window bytes never written since reset read as zero.
    assign copy_byte = fwd_reg ? fwd_data_reg : (zero_reg ? 8'h00 : rd_data_reg);

    // Command execution.
    always_comb begin
        state_next   = state_reg;
        fin_next     = fin_reg;
        prod_next    = prod_reg;
        tok_next     = tok_reg;
        cur_pos_next = cur_pos_reg;
        remain_next  = remain_reg;
        last_next    = last_reg;
        q_pop        = 1'b0;
        we           = 1'b0;
        wd           = 8'h00;
        rd_en        = 1'b0;
        rd_addr      = cur_pos_reg;
        out_load     = 1'b0;
        ob           = 8'h00;
        ov           = 1'b0;
        ol           = 1'b0;
        os           = ST_RUN;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty && slot_free) begin
                    q_pop    = 1'b1;
                    out_load = 1'b1;
                    ol       = 1'b1;
                    if (fin_reg != ST_RUN) begin
                        os = fin_reg;
                    end else begin
                        case (head.kind)
                            K_CTRL: begin
                                fin_next = stop_eval(prod_reg, tok_reg, cfg.out_length, lim,
                                                     head.last);
                                os       = fin_next;
                            end
                            K_REF0: begin
                                fin_next = head.last ? ST_TRUNC : ST_RUN;
                                os       = fin_next;
                            end
                            K_LIT: begin
                                we        = 1'b1;
                                wd        = head.data[7:0];
                                ob        = head.data[7:0];
                                ov        = 1'b1;
                                prod_next = prod_inc;
                                tok_next  = tok_inc;
                                fin_next  = stop_eval(prod_inc, tok_inc, cfg.out_length, lim,
                                                      head.last);
                                os        = fin_next;
                            end
                            K_COPY: begin
                                out_load     = 1'b0;
                                rd_en        = 1'b1;
                                rd_addr      = head.data;
                                cur_pos_next = head.data + 1'b1;
                                remain_next  = {1'b0, head.len} + 5'd3;
                                last_next    = head.last;
                                state_next   = B_COPY;
                            end
                            default: begin
                                os = fin_reg;
                            end
                        endcase
                    end
                end
            end
            B_COPY: begin
                if (slot_free) begin
                    out_load  = 1'b1;
                    ob        = copy_byte;
                    ov        = 1'b1;
                    we        = 1'b1;
                    wd        = copy_byte;
                    prod_next = prod_inc;
                    if (len_done || (remain_reg == 5'd1)) begin
                        tok_next   = tok_inc;
                        fin_next   = stop_eval(prod_inc, tok_inc, cfg.out_length, lim,
                                               last_reg);
                        ol         = 1'b1;
                        os         = fin_next;
                        state_next = B_IDLE;
                    end else begin
                        rd_en        = 1'b1;
                        cur_pos_next = cur_pos_reg + 1'b1;
                        remain_next  = remain_reg - 5'd1;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Write pointer and fill marker of the window.
    always_comb begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (we) begin
            wp_next = wp_reg + 1'b1;
            if (wp_reg == '1) begin
                wrapped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            fin_reg     <= ST_RUN;
            prod_reg    <= '0;
            tok_reg     <= '0;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fin_reg     <= fin_next;
            prod_reg    <= prod_next;
            tok_reg     <= tok_next;
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Copy progress and output payload.
    always_ff @(posedge aclk) begin
        cur_pos_reg <= cur_pos_next;
        remain_reg  <= remain_next;
        last_reg    <= last_next;
        if (out_load) begin
            out_byte_reg  <= ob;
            out_valid_reg <= ov;
            run_last_reg  <= ol;
            status_reg    <= os;
        end
    end

    // History window with a registered read; a read of the byte written in the
    // same cycle takes the write data instead.
    always_ff @(posedge aclk) begin
        if (we) begin
            win_mem[wp_reg] <= wd;
        end
        if (rd_en) begin
            rd_data_reg  <= win_mem[rd_addr];
            fwd_reg      <= we && (rd_addr == wp_reg);
            fwd_data_reg <= wd;
            zero_reg     <= !(wrapped_reg || (rd_addr < wp_reg));
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_out_valid = out_valid_reg;
    assign m_run_last  = run_last_reg;
    assign m_status    = status_reg;

endmodule

@@ rtl/lzss_window_decoder_core.sv @@
// LZSS window decoder top level: configuration registers, front, queue and back.
// Depends on lzwd_pkg, lzwd_front, lzwd_cmd_fifo and lzwd_back.

// The decoder takes one compressed byte per transfer and returns one result per
// decompressed byte, or a single status-only result for a byte that yields no
// output. A copy takes one registered read of the 4096-byte history window per
// byte, the first read started when the copy command is taken from the queue,
// with the window write of each byte in the same cycle as the read of the next.
// Input is classified by the front and held in a four-entry command queue, so
// input keeps flowing while a copy runs and a result waits at the output
// register. The window reads as zero after reset through a fill marker on the
// write pointer, so there is no clearing pass and items are taken right after
// reset. The user must write configuration only while the block is idle; the
// block itself does not enforce it.
module lzss_window_decoder_core #(
    parameter int COUNT_BITS = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [lzwd_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_in_byte,
    input  logic                       s_in_last,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_out_valid,
    output logic                       m_run_last,
    output logic [1:0]                 m_status
);
    import lzwd_pkg::*;

    cfg_t cfg_reg;
    cmd_t q_data;
    cmd_t q_head;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.out_length  <= OUT_LENGTH_RST;
            cfg_reg.token_limit <= TOKEN_LIMIT_DFLT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OUT_LENGTH:  cfg_reg.out_length  <= cfg_wr_data;
                REG_TOKEN_LIMIT: cfg_reg.token_limit <= cfg_wr_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    lzwd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    lzwd_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    lzwd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_valid (m_out_valid),
        .m_run_last  (m_run_last),
        .m_status    (m_status)
    );

endmodule

@@ rtl/lzwd_checker.sv @@
// Port-level checker for the LZSS window decoder and its bind to the top level.
// Depends on lzwd_pkg and the assertion macro header.
`include "lzss_window_decoder_core_assert.svh"

module lzwd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_out_valid,
    input logic       m_run_last,
    input logic [1:0] m_status
);
    import lzwd_pkg::*;

    logic       stopped_reg;
    logic [1:0] stop_code_reg;
    logic [11:0] out_bus;

    assign out_bus = {m_out_byte, m_out_valid, m_run_last, m_status};

    // Remember the first terminal status that was transferred.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stopped_reg   <= 1'b0;
            stop_code_reg <= ST_RUN;
        end else if (m_valid && m_ready && m_run_last && (m_status != ST_RUN)
                     && !stopped_reg) begin
            stopped_reg   <= 1'b1;
            stop_code_reg <= m_status;
        end
    end

    // A stalled result holds its payload.
    `LZWD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_bus), "stalled result changed")
    // A status-only result carries a zero byte and closes its item.
    `LZWD_ASSERT_IMPL(a_status_only, aclk, aresetn, m_valid && !m_out_valid, (m_out_byte == 8'h00) && m_run_last, "bad status-only result")
    // Results before the last of an item are data bytes with running status.
    `LZWD_ASSERT_IMPL(a_mid_item, aclk, aresetn, m_valid && !m_run_last, m_out_valid && (m_status == ST_RUN), "bad mid-item result")
    // Once stopped, every result repeats the final status without data.
    `LZWD_ASSERT_IMPL(a_after_stop, aclk, aresetn, m_valid && stopped_reg, !m_out_valid && m_run_last && (m_status == stop_code_reg), "output after stop")

endmodule

bind lzss_window_decoder_core lzwd_checker u_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte),
    .m_out_valid (m_out_valid),
    .m_run_last  (m_run_last),
    .m_status    (m_status)
);
